// ----- hw/rtl/dmh_pkg.sv -----
// dmh_pkg: shared types and codes of the d-ary min-heap priority queue
// no dependencies
package dmh_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_PEEK    = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  localparam int unsigned KeyWidth    = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned KindWidth   = 2;

  // bias that turns signed key order into unsigned order
  localparam logic [KeyWidth-1:0] KeyBias = {1'b1, {(KeyWidth-1){1'b0}}};

  // request from the sequencer to the shared compare unit
  typedef struct packed {
    logic                clear;
    logic                take;
    logic [KeyWidth-1:0] cand_key;
  } cmp_req_t;

endpackage

// ----- hw/rtl/dmh_cmp_unit.sv -----
// dmh_cmp_unit: shared running-minimum compare unit used by sift-down
// depends on dmh_pkg
module dmh_cmp_unit #(
  parameter int unsigned AddrWidth = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dmh_pkg::cmp_req_t       req_i,
  input  logic [AddrWidth-1:0]    cand_addr_i,
  input  logic [dmh_pkg::KeyWidth-1:0] ref_key_i,
  output logic                    found_o,
  output logic [AddrWidth-1:0]    best_addr_o,
  output logic [dmh_pkg::KeyWidth-1:0] best_key_o
);
  import dmh_pkg::*;

  logic                 found_q, found_d;
  logic [AddrWidth-1:0] addr_q, addr_d;
  logic [KeyWidth-1:0]  key_q, key_d;
  logic [KeyWidth-1:0]  cur_key;

  assign cur_key = found_q ? key_q : ref_key_i;

  always_comb begin
    found_d = found_q;
    addr_d  = addr_q;
    key_d   = key_q;
    if (req_i.clear) begin
      found_d = 1'b0;
    end else if (req_i.take && (req_i.cand_key < cur_key)) begin
      found_d = 1'b1;
      addr_d  = cand_addr_i;
      key_d   = req_i.cand_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    key_q  <= key_d;
  end

  assign found_o     = found_q;
  assign best_addr_o = addr_q;
  assign best_key_o  = key_q;

endmodule

// ----- hw/rtl/dary_min_heap_priority_queue_unit.sv -----
// d-ary min-heap priority queue, top level with sequencer and heap memory
// depends on dmh_pkg and dmh_cmp_unit
// insert sifts the new entry up level by level; extract moves the last entry to the root
// and sifts it down, examining up to ARITY children per level; an extract that empties the heap skips this
// one item at a time; the next item is taken in the cycle its predecessor's result appears
// reset clears the entry count, sequencer and result valid; memory contents need no clearing
module dary_min_heap_priority_queue_unit #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ARITY    = 4,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic signed [31:0]          key_i,
  input  logic [ID_WIDTH-1:0]         item_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          out_key_o,
  output logic [ID_WIDTH-1:0]         out_item_id_o,
  output logic [1:0]                  status_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);
  import dmh_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned JW = $clog2(ARITY + 1);
  localparam int unsigned PW = AW + $clog2(ARITY) + 2;
  // parent index by reciprocal multiplication
  localparam int unsigned DivShift = AW + $clog2(ARITY);
  localparam int unsigned DivMul   = ((1 << DivShift) + ARITY - 1) / ARITY;
  localparam int unsigned ProdW    = AW + DivShift;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_UPRD  = 11'b00000000010,
    ST_UPCMP = 11'b00000000100,
    ST_EXRD0 = 11'b00000001000,
    ST_EXRDL = 11'b00000010000,
    ST_EXWR0 = 11'b00000100000,
    ST_DNRD  = 11'b00001000000,
    ST_DNCMP = 11'b00010000000,
    ST_DNMOV = 11'b00100000000,
    ST_DNFIN = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [KeyWidth-1:0] key_mem [CAPACITY];
  logic [ID_WIDTH-1:0] id_mem  [CAPACITY];
  logic [KeyWidth-1:0] rd_key_q;
  logic [ID_WIDTH-1:0] rd_id_q;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [KeyWidth-1:0] wr_key;
  logic [ID_WIDTH-1:0] wr_id;
  logic                mov_q;
  logic [AW-1:0]       mov_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      id_mem[wr_addr]  <= wr_id;
    end
    // id of the moved child arrives from the read issued in the move cycle
    if (mov_q) begin
      id_mem[mov_addr_q] <= rd_id_q;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_id_q  <= id_mem[rd_addr];
    end
  end

  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [KeyWidth-1:0] hkey_q, hkey_d;
  logic [ID_WIDTH-1:0] hid_q, hid_d;
  logic [JW-1:0]       j_q, j_d;
  logic [PW-1:0]       cand_q, cand_d;
  logic [KeyWidth-1:0] okey_q, okey_d;
  logic [ID_WIDTH-1:0] oid_q, oid_d;
  logic [1:0]          ostat_q, ostat_d;
  logic                ovalid_q, ovalid_d;
  logic                res_load;
  logic [KeyWidth-1:0] res_key_q;
  logic [ID_WIDTH-1:0] res_id_q;
  logic [1:0]          res_stat_q;
  logic [CW-1:0]       res_count_q;

  cmp_req_t            creq;
  logic                c_found;
  logic [AW-1:0]       c_addr;
  logic [KeyWidth-1:0] c_key;
  logic [AW-1:0]       c_cand_addr;
  logic [AW-1:0]       parent;
  logic [ProdW-1:0]    parent_prod;
  logic [PW-1:0]       first_child;

  assign parent_prod = ProdW'(pos_q - AW'(1)) * ProdW'(DivMul);
  assign parent      = parent_prod[DivShift +: AW];
  assign first_child = PW'(pos_q) * PW'(ARITY) + PW'(1);
  assign c_cand_addr = cand_q[AW-1:0] - AW'(1);

  dmh_cmp_unit #(.AddrWidth(AW)) u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (creq),
    .cand_addr_i(c_cand_addr),
    .ref_key_i  (hkey_q),
    .found_o    (c_found),
    .best_addr_o(c_addr),
    .best_key_o (c_key)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign res_load   = (state_q == ST_OUT) && (!ovalid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    hkey_d   = hkey_q;
    hid_d    = hid_q;
    j_d      = j_q;
    cand_d   = cand_q;
    okey_d   = okey_q;
    oid_d    = oid_q;
    ostat_d  = ostat_q;
    ovalid_d = ovalid_q;
    rd_en    = 1'b0;
    rd_addr  = pos_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_key   = hkey_q;
    wr_id    = hid_q;
    creq     = '{clear: 1'b0, take: 1'b0, cand_key: rd_key_q};
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          okey_d  = '0;
          oid_d   = '0;
          ostat_d = STATUS_OK;
          unique case (kind_i)
            KIND_INSERT: begin
              if (count_q >= CW'(CAPACITY)) begin
                ostat_d = STATUS_FULL;
                state_d = ST_OUT;
              end else begin
                hkey_d  = key_i ^ KeyBias;
                hid_d   = item_id_i;
                pos_d   = count_q[AW-1:0];
                count_d = count_q + CW'(1);
                state_d = ST_UPRD;
              end
            end
            KIND_EXTRACT, KIND_PEEK: begin
              if (count_q == '0) begin
                ostat_d = STATUS_EMPTY;
                state_d = ST_OUT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = (kind_i == KIND_EXTRACT) ? ST_EXRD0 : ST_EXRDL;
                if (kind_i == KIND_EXTRACT) begin
                  count_d = count_q - CW'(1);
                end
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_UPRD: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
          state_d = ST_UPCMP;
        end
      end
      ST_UPCMP: begin
        wr_en = 1'b1;
        if (rd_key_q <= hkey_q) begin
          state_d = ST_OUT;
        end else begin
          wr_key  = rd_key_q;
          wr_id   = rd_id_q;
          pos_d   = parent;
          state_d = ST_UPRD;
        end
      end
      ST_EXRD0: begin
        // root captured, now fetch the last entry
        okey_d  = rd_key_q ^ KeyBias;
        oid_d   = rd_id_q;
        if (count_q == '0) begin
          state_d = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = count_q[AW-1:0];
          state_d = ST_EXWR0;
        end
      end
      ST_EXRDL: begin
        okey_d  = rd_key_q ^ KeyBias;
        oid_d   = rd_id_q;
        state_d = ST_OUT;
      end
      ST_EXWR0: begin
        hkey_d  = rd_key_q;
        hid_d   = rd_id_q;
        pos_d   = '0;
        state_d = ST_DNRD;
      end
      ST_DNRD: begin
        creq.clear = 1'b1;
        j_d        = '0;
        cand_d     = first_child;
        if (first_child >= PW'(count_q)) begin
          state_d = ST_DNFIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = first_child[AW-1:0];
          cand_d  = first_child + PW'(1);
          j_d     = JW'(1);
          state_d = ST_DNCMP;
        end
      end
      ST_DNCMP: begin
        creq.take = 1'b1;
        if (j_q < JW'(ARITY) && cand_q < PW'(count_q)) begin
          rd_en   = 1'b1;
          rd_addr = cand_q[AW-1:0];
          cand_d  = cand_q + PW'(1);
          j_d     = j_q + JW'(1);
        end else begin
          state_d = ST_DNMOV;
        end
      end
      ST_DNMOV: begin
        if (c_found) begin
          wr_en   = 1'b1;
          wr_key  = c_key;
          rd_en   = 1'b1;
          rd_addr = c_addr;
          pos_d   = c_addr;
          state_d = ST_DNRD;
        end else begin
          state_d = ST_DNFIN;
        end
      end
      ST_DNFIN: begin
        wr_en   = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mov_q <= 1'b0;
    end else begin
      mov_q <= (state_q == ST_DNMOV) && c_found;
    end
  end
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DNMOV) && c_found) begin
      mov_addr_q <= pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    hkey_q  <= hkey_d;
    hid_q   <= hid_d;
    j_q     <= j_d;
    cand_q  <= cand_d;
    okey_q  <= okey_d;
    oid_q   <= oid_d;
    ostat_q <= ostat_d;
  end

  // result register, held while the result is stalled
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_key_q   <= okey_q;
      res_id_q    <= oid_q;
      res_stat_q  <= ostat_q;
      res_count_q <= count_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_key_o     = res_key_q;
  assign out_item_id_o = res_id_q;
  assign status_o      = res_stat_q;
  assign entry_count_o = res_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_key_o))
    else $error("stalled result changed");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && !out_stall_i |=> !in_stall_o)
    else $error("sequencer did not return to idle");
`endif

endmodule

// ----- verif/dary_min_heap_priority_queue_unit_checker.sv -----
// checker for the d-ary min-heap priority queue: watches both channels,
// predicts each result with its own heap copy and compares field by field
// depends on dmh_pkg
module dary_min_heap_priority_queue_unit_checker #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ARITY    = 4,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    kind_i,
  input  logic signed [31:0]            key_i,
  input  logic [ID_WIDTH-1:0]           item_id_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [31:0]            out_key_i,
  input  logic [ID_WIDTH-1:0]           out_item_id_i,
  input  logic [1:0]                    status_i,
  input  logic [$clog2(CAPACITY+1)-1:0] entry_count_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmh_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic signed [31:0]  key;
    logic [ID_WIDTH-1:0] id;
    status_e             status;
    logic [CW-1:0]       count;
  } heap_result_t;

  logic signed [31:0]  heap_key[CAPACITY];
  logic [ID_WIDTH-1:0] heap_id[CAPACITY];
  int unsigned         fill_level;
  heap_result_t        expected_q[$];

  function automatic heap_result_t heap_apply(logic [1:0] kind, logic signed [31:0] key,
                                               logic [ID_WIDTH-1:0] id);
    heap_result_t r;
    int unsigned pos, par, best, c;
    logic signed [31:0] k;
    logic [ID_WIDTH-1:0] d;
    r = '0;
    r.status = STATUS_OK;
    case (kind_e'(kind))
      KIND_INSERT: begin
        if (fill_level >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          pos = fill_level;
          fill_level++;
          while (pos > 0) begin
            par = (pos - 1) / ARITY;
            if (heap_key[par] <= key) break;
            heap_key[pos] = heap_key[par];
            heap_id[pos] = heap_id[par];
            pos = par;
          end
          heap_key[pos] = key;
          heap_id[pos] = id;
        end
      end
      KIND_EXTRACT, KIND_PEEK: begin
        if (fill_level == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.key = heap_key[0];
          r.id = heap_id[0];
          if (kind_e'(kind) == KIND_EXTRACT) begin
            fill_level--;
            if (fill_level > 0) begin
              k = heap_key[fill_level];
              d = heap_id[fill_level];
              pos = 0;
              forever begin
                best = pos;
                for (int j = 0; j < ARITY; j++) begin
                  c = pos * ARITY + 1 + j;
                  if (c >= fill_level) break;
                  if (heap_key[c] < (best == pos ? k : heap_key[best])) best = c;
                end
                if (best == pos) break;
                heap_key[pos] = heap_key[best];
                heap_id[pos] = heap_id[best];
                pos = best;
              end
              heap_key[pos] = k;
              heap_id[pos] = d;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = CW'(fill_level);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t exp_r;
    if (!rst_ni) begin
      fill_level = 0;
      expected_q.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        result_count_o <= result_count_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result key %0d id %0d status %0d count %0d", $realtime,
                   out_key_i, out_item_id_i, status_i, entry_count_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.key !== out_key_i || exp_r.id !== out_item_id_i ||
              exp_r.status !== status_i || exp_r.count !== entry_count_i) begin
            $display("%0t mismatch expected key %0d id %0d status %0d count %0d", $realtime,
                     exp_r.key, exp_r.id, exp_r.status, exp_r.count);
            $display("%0t          actual   key %0d id %0d status %0d count %0d", $realtime,
                     out_key_i, out_item_id_i, status_i, entry_count_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(heap_apply(kind_i, key_i, item_id_i));
    end
  end
endmodule

// ----- verif/dary_min_heap_priority_queue_unit_test.sv -----
// testbench top for the d-ary min-heap priority queue: drives directed and
// random operations with random idling; depends on dmh_pkg, the checker and the rtl
module dary_min_heap_priority_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dmh_pkg::*;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = KIND_NOP;
  logic signed [31:0] key_i = '0;
  logic [15:0] item_id_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] out_key_o;
  logic [15:0] out_item_id_o;
  logic [1:0] status_o;
  logic [CW-1:0] entry_count_o;
  int fail_count, pending, result_count;
  int cycle_count = 0;
  int sent_count = 0;
  bit calm = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  dary_min_heap_priority_queue_unit u_dut (.*);

  dary_min_heap_priority_queue_unit_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .key_i, .item_id_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_key_i(out_key_o),
    .out_item_id_i(out_item_id_o), .status_i(status_o), .entry_count_i(entry_count_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[dary_min_heap_priority_queue_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 17);
  end

  task automatic send_op(kind_e kind, logic signed [31:0] key, logic [15:0] id);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    kind_i <= kind;
    key_i <= key;
    item_id_i <= id;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_count++;
  endtask

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(3))
      0: return $signed($urandom_range(15)) - 8;
      1: return 32'sh7fffffff - $urandom_range(3);
      2: return 32'sh80000000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sz;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_op(KIND_EXTRACT, 0, 0);
    send_op(KIND_PEEK, 0, 0);
    send_op(KIND_NOP, 0, 0);
    send_op(KIND_INSERT, 32'sh7fffffff, 16'hffff);
    send_op(KIND_INSERT, 32'sh80000000, 16'h0000);
    send_op(KIND_INSERT, 5, 16'h5555);
    send_op(KIND_INSERT, 5, 16'haaaa);
    send_op(KIND_INSERT, -1, 16'h00ff);
    send_op(KIND_INSERT, 5, 16'hff00);
    send_op(KIND_PEEK, 0, 0);
    send_op(KIND_NOP, 32'shffffffff, 16'hffff);
    repeat (7) send_op(KIND_EXTRACT, 0, 0);
    // fill to capacity, hit the full case, drain most of it
    calm = 1'b1;
    for (int i = 0; i < CAPACITY; i++) send_op(KIND_INSERT, pick_key(), 16'($urandom));
    calm = 1'b0;
    send_op(KIND_INSERT, 1, 16'h1234);
    send_op(KIND_PEEK, 0, 0);
    for (int i = 0; i < CAPACITY - 300; i++) send_op(KIND_EXTRACT, 0, 0);
    // random phases of fills and drains with mostly small sizes
    while (sent_count < 1900) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
      for (int i = 0; i < sz; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: send_op(KIND_INSERT, pick_key(), 16'($urandom));
          6, 7: send_op(KIND_EXTRACT, 0, 0);
          8: send_op(KIND_PEEK, 0, 0);
          default: send_op(kind_e'($urandom_range(3)), $urandom, 16'($urandom));
        endcase
      end
      for (int i = 0; i < sz; i++) send_op(($urandom_range(4) == 0) ? KIND_PEEK : KIND_EXTRACT,
                                           $urandom, 16'($urandom));
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("ran %0d operations, %0d results checked, including full and empty heap cases",
             sent_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[dary_min_heap_priority_queue_unit] OK");
    end else begin
      $display("[dary_min_heap_priority_queue_unit] ERROR");
    end
    $finish;
  end
endmodule
